// ----- rtl/msi_pkg.sv -----
// msi_pkg: shared types and constants for the merge sort with index unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package msi_pkg;
    localparam int MAX_KEYS_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int POS_W        = 6;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last_key;
    } entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_MERGE,
        ST_COPY,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

// ----- rtl/msi_front.sv -----
// msi_front: input stage, a two-entry queue between the input port and the sorter.
// Depends on msi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msi_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire msi_pkg::entry_t    in_entry,
    output logic                    q_valid,
    input  wire logic               q_take,
    output msi_pkg::entry_t         q_entry
);
    msi_pkg::entry_t q_mem_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_entry  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= in_entry;
    end
endmodule
`default_nettype wire

// ----- rtl/msi_back.sv -----
// msi_back: key/position store and top-down merge sequencer with result register.
// Depends on msi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msi_back #(
    parameter int MAX_KEYS = msi_pkg::MAX_KEYS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    output logic                           q_take,
    input  wire msi_pkg::entry_t           q_entry,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [msi_pkg::KEY_W-1:0]      sorted_key,
    output logic [msi_pkg::POS_W-1:0]      original_position,
    output logic                           last_result,
    output logic                           overflowed
);
    localparam int AW   = $clog2(MAX_KEYS);
    localparam int CW   = $clog2(MAX_KEYS + 1);
    // Deepest stack: each split level keeps its parent and a pending sibling.
    localparam int MAXD = 2 * AW + 1;
    localparam int SPW  = $clog2(MAXD + 1);
    localparam int WW   = msi_pkg::KEY_W + msi_pkg::POS_W;

    typedef logic [WW-1:0] word_t;

    // mem_a holds the set, mem_b is the merge scratch area.
    word_t           mem_a [MAX_KEYS];
    word_t           mem_b [MAX_KEYS];

    msi_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg;
    logic            ovf_reg;
    // Recursion is walked with an explicit stack of ranges; each frame
    // records whether its children are already sorted.
    logic [AW-1:0]   s_stk_reg [MAXD];
    logic [AW-1:0]   e_stk_reg [MAXD];
    logic            d_stk_reg [MAXD];
    logic [SPW-1:0]  sp_reg;
    logic [AW:0]     a_reg, b_reg, k_reg;
    logic [AW-1:0]   s_reg, e_reg, m_reg;
    logic [CW-1:0]   emit_idx_reg;
    logic            rd_ok_reg;
    logic            cw_ok_reg;
    logic [AW-1:0]   cwaddr_reg;
    word_t           cb_reg;
    word_t           wa_reg, wb_reg;
    logic            ov_reg;
    word_t           od_reg;
    logic            ol_reg;
    logic            oo_reg;

    logic [SPW-1:0]  top_idx;
    logic [AW-1:0]   top_s, top_e, mid;
    logic            top_d;
    logic [AW:0]     rsum;
    logic [AW:0]     len;
    logic            take_left;
    logic            load_go;
    logic            out_free;
    logic            can_store;
    logic            emit_more;
    logic [AW-1:0]   rd_addr;

    assign top_idx = sp_reg - 1'b1;
    assign top_s   = s_stk_reg[top_idx];
    assign top_e   = e_stk_reg[top_idx];
    assign top_d   = d_stk_reg[top_idx];
    assign rsum    = {1'b0, top_s} + {1'b0, top_e};
    assign mid     = rsum[AW:1];
    assign len     = {1'b0, e_reg} - {1'b0, s_reg};

    // On equal keys the right half goes first.
    assign take_left = (a_reg <= {1'b0, m_reg}) &&
                       (!(b_reg <= {1'b0, e_reg}) ||
                        (wa_reg[WW-1:msi_pkg::POS_W] < wb_reg[WW-1:msi_pkg::POS_W]));

    assign load_go   = q_valid && q_take;
    assign out_free  = !ov_reg || !out_stall;
    assign can_store = (count_reg < CW'(MAX_KEYS));
    assign emit_more = (emit_idx_reg < count_reg);
    assign rd_addr   = (state_reg == msi_pkg::ST_EMIT) ? emit_idx_reg[AW-1:0]
                                                       : a_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msi_pkg::ST_LOAD:
                if (load_go && q_entry.last_key)
                    state_next = msi_pkg::ST_PASS;
            msi_pkg::ST_PASS:
                if (sp_reg == '0)
                    state_next = msi_pkg::ST_EMIT;
                else if (top_s < top_e && top_d)
                    state_next = msi_pkg::ST_MERGE;
            msi_pkg::ST_MERGE:
                if (rd_ok_reg && k_reg == len)
                    state_next = msi_pkg::ST_COPY;
            msi_pkg::ST_COPY:
                if (k_reg == len)
                    state_next = msi_pkg::ST_PASS;
            msi_pkg::ST_EMIT:
                if (out_free && !emit_more)
                    state_next = msi_pkg::ST_LOAD;
            default:
                state_next = msi_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        q_take = (state_reg == msi_pkg::ST_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= msi_pkg::ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            sp_reg       <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            k_reg        <= '0;
            s_reg        <= '0;
            e_reg        <= '0;
            m_reg        <= '0;
            emit_idx_reg <= '0;
            rd_ok_reg    <= 1'b0;
            cw_ok_reg    <= 1'b0;
            ov_reg       <= 1'b0;
            ol_reg       <= 1'b0;
            oo_reg       <= 1'b0;
            for (int i = 0; i < MAXD; i++)
            begin
                s_stk_reg[i] <= '0;
                e_stk_reg[i] <= '0;
                d_stk_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // copy-back write lands in the cycle after the scratch read
            cw_ok_reg <= (state_reg == msi_pkg::ST_COPY);
            case (state_reg)
                msi_pkg::ST_LOAD:
                    if (load_go)
                    begin
                        if (can_store)
                            count_reg <= count_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                        if (q_entry.last_key)
                        begin
                            s_stk_reg[0] <= '0;
                            e_stk_reg[0] <= can_store ? count_reg[AW-1:0]
                                                      : AW'(MAX_KEYS - 1);
                            d_stk_reg[0] <= 1'b0;
                            sp_reg       <= SPW'(1);
                        end
                    end
                msi_pkg::ST_PASS:
                    if (sp_reg == '0)
                        emit_idx_reg <= '0;
                    else if (top_s >= top_e)
                        sp_reg <= sp_reg - 1'b1;
                    else if (top_d)
                    begin
                        s_reg     <= top_s;
                        e_reg     <= top_e;
                        m_reg     <= mid;
                        a_reg     <= {1'b0, top_s};
                        b_reg     <= {1'b0, mid} + 1'b1;
                        k_reg     <= '0;
                        rd_ok_reg <= 1'b0;
                        sp_reg    <= sp_reg - 1'b1;
                    end
                    else
                    begin
                        d_stk_reg[top_idx]       <= 1'b1;
                        s_stk_reg[sp_reg]        <= mid + 1'b1;
                        e_stk_reg[sp_reg]        <= top_e;
                        d_stk_reg[sp_reg]        <= 1'b0;
                        s_stk_reg[sp_reg + 1'b1] <= top_s;
                        e_stk_reg[sp_reg + 1'b1] <= mid;
                        d_stk_reg[sp_reg + 1'b1] <= 1'b0;
                        sp_reg                   <= sp_reg + SPW'(2);
                    end
                msi_pkg::ST_MERGE:
                begin
                    // Read cycle then compare cycle, alternating.
                    if (!rd_ok_reg)
                        rd_ok_reg <= 1'b1;
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        if (take_left)
                            a_reg <= a_reg + 1'b1;
                        else
                            b_reg <= b_reg + 1'b1;
                        if (k_reg == len)
                            k_reg <= '0;
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                msi_pkg::ST_COPY:
                    k_reg <= k_reg + 1'b1;
                msi_pkg::ST_EMIT:
                    if (out_free)
                    begin
                        if (emit_more)
                        begin
                            ov_reg       <= 1'b1;
                            ol_reg       <= (emit_idx_reg + 1'b1 == count_reg);
                            oo_reg       <= ovf_reg;
                            emit_idx_reg <= emit_idx_reg + 1'b1;
                        end
                        else
                        begin
                            ov_reg    <= 1'b0;
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                    end
                default:
                    ;
            endcase
        end
    end

    // Memory ports: one write and registered reads at two addresses per cycle.
    always_ff @(posedge clk)
    begin
        if (load_go && can_store)
            mem_a[count_reg[AW-1:0]] <= {q_entry.key, msi_pkg::POS_W'(count_reg)};
        else if (cw_ok_reg)
            mem_a[cwaddr_reg] <= cb_reg;
        wa_reg <= mem_a[rd_addr];
        wb_reg <= mem_a[b_reg[AW-1:0]];
        if (state_reg == msi_pkg::ST_MERGE && rd_ok_reg)
            mem_b[k_reg[AW-1:0]] <= take_left ? wa_reg : wb_reg;
        cb_reg     <= mem_b[k_reg[AW-1:0]];
        cwaddr_reg <= s_reg + k_reg[AW-1:0];
        if (state_reg == msi_pkg::ST_EMIT && out_free && emit_more)
            od_reg <= mem_a[rd_addr];
    end

    assign out_valid         = ov_reg;
    assign sorted_key        = od_reg[WW-1:msi_pkg::POS_W];
    assign original_position = od_reg[msi_pkg::POS_W-1:0];
    assign last_result       = ol_reg;
    assign overflowed        = oo_reg;
endmodule
`default_nettype wire

// ----- rtl/merge_sort_with_index_unit.sv -----
// Top level of the merge sort with index unit; depends on msi_pkg, msi_front, msi_back.
// A set is loaded into the store, sorted top-down by merge passes (each merge alternates
// a read step and a compare step, then copies back from scratch) and emitted in order.
// Keys load one per cycle while the sorter is loading and in_stall is low; results leave
// one per cycle while out_stall is low. A new set is taken only after the last result has left.
// Reset (rst_n, async, active low) clears all control state; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module merge_sort_with_index_unit #(
    parameter int MAX_KEYS = msi_pkg::MAX_KEYS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [msi_pkg::KEY_W-1:0] key,
    input  wire logic                      last_key,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [msi_pkg::KEY_W-1:0]      sorted_key,
    output logic [msi_pkg::POS_W-1:0]      original_position,
    output logic                           last_result,
    output logic                           overflowed
);
    msi_pkg::entry_t in_entry, q_entry;
    logic            q_valid, q_take;

    assign in_entry.key      = key;
    assign in_entry.last_key = last_key;

    // Front: two-entry queue that accepts input transfers while the sorter works, until it is full.
    msi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_entry (in_entry),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_entry  (q_entry)
    );

    // Back: store, merge sequencer and output register.
    msi_back #(.MAX_KEYS(MAX_KEYS)) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_take            (q_take),
        .q_entry           (q_entry),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sorted_key        (sorted_key),
        .original_position (original_position),
        .last_result       (last_result),
        .overflowed        (overflowed)
    );

`ifndef SYNTH
    // A stalled result must hold its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_key))
        else $error("result changed under stall");
    // An input stall implies that the queue holds entries.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_valid)
        else $error("stall without queued entries");
`endif
endmodule
`default_nettype wire
